>>> src/x86_integer_alu_with_flags_macros.svh
// Assertion macros for the x86 integer ALU.
// Used by x86_integer_alu_with_flags.sv; needs nothing else.
`ifndef X86_INTEGER_ALU_WITH_FLAGS_MACROS_SVH
`define X86_INTEGER_ALU_WITH_FLAGS_MACROS_SVH

// Condition in this cycle implies a consequence in the next cycle.
`define X86_ALU_ASSERT_NEXT(label, clk, rst_n, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error(msg);

// Condition implies a consequence in the same cycle.
`define X86_ALU_ASSERT_NOW(label, clk, rst_n, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error(msg);

`endif

>>> src/x86alu_pkg.sv
// Shared types and codes for the x86 integer ALU.
// No dependencies.
package x86alu_pkg;

    localparam int MAX_WIDTH = 32;
    localparam int OP_W      = 5;
    localparam int WSEL_W    = 2;

    localparam logic [OP_W-1:0] OP_ADD  = 5'd0;
    localparam logic [OP_W-1:0] OP_ADC  = 5'd1;
    localparam logic [OP_W-1:0] OP_SUB  = 5'd2;
    localparam logic [OP_W-1:0] OP_SBB  = 5'd3;
    localparam logic [OP_W-1:0] OP_CMP  = 5'd4;
    localparam logic [OP_W-1:0] OP_INC  = 5'd5;
    localparam logic [OP_W-1:0] OP_DEC  = 5'd6;
    localparam logic [OP_W-1:0] OP_NEG  = 5'd7;
    localparam logic [OP_W-1:0] OP_AND  = 5'd8;
    localparam logic [OP_W-1:0] OP_OR   = 5'd9;
    localparam logic [OP_W-1:0] OP_TEST = 5'd10;
    localparam logic [OP_W-1:0] OP_XOR  = 5'd11;
    localparam logic [OP_W-1:0] OP_NOT  = 5'd12;
    localparam logic [OP_W-1:0] OP_SHL  = 5'd13;
    localparam logic [OP_W-1:0] OP_SHR  = 5'd14;
    localparam logic [OP_W-1:0] OP_SAR  = 5'd15;
    localparam logic [OP_W-1:0] OP_ROL  = 5'd16;
    localparam logic [OP_W-1:0] OP_ROR  = 5'd17;

    localparam logic [WSEL_W-1:0] WSEL_8  = 2'd0;
    localparam logic [WSEL_W-1:0] WSEL_16 = 2'd1;

    typedef struct packed {
        logic cf;
        logic of;
        logic zf;
        logic sf;
        logic pf;
    } t_flags;

endpackage

>>> src/x86_integer_alu_with_flags.sv
// x86 integer ALU with CF, OF, ZF, SF and PF flag register.
// Path: an accepted word passes the input register and then the result register, which drives the outputs.
// Throughput: one word per cycle unless stalled; flags are fed back from the flag register each cycle.
// Reset: synchronous, active low; clears the flags and both valid bits.
// Depends on x86alu_pkg and x86_integer_alu_with_flags_macros.svh.
`include "x86_integer_alu_with_flags_macros.svh"

module x86_integer_alu_with_flags (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic [x86alu_pkg::OP_W-1:0]         i_operation,
    input  logic [x86alu_pkg::WSEL_W-1:0]       i_operand_width,
    input  logic [x86alu_pkg::MAX_WIDTH-1:0]    i_dest_value,
    input  logic [x86alu_pkg::MAX_WIDTH-1:0]    i_src_value,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic [x86alu_pkg::MAX_WIDTH-1:0]    o_result_value,
    output logic                                o_write_back,
    output logic                                o_carry_out,
    output logic                                o_overflow_out,
    output logic                                o_zero_out,
    output logic                                o_sign_out,
    output logic                                o_parity_out
);
    import x86alu_pkg::*;

    // The design is two registers deep. The input register holds the word
    // being executed; all of the arithmetic, logic, shift and flag work is a
    // single combinational pass from it to the result register. The flag
    // register updates on the same edge as the result register, so the next
    // word (ADC or SBB in particular) sees the fresh carry right away.

    // Input register.
    logic                   r_in_valid;
    logic [OP_W-1:0]        r_in_op;
    logic [WSEL_W-1:0]      r_in_wsel;
    logic [MAX_WIDTH-1:0]   r_in_dest;
    logic [MAX_WIDTH-1:0]   r_in_src;

    // Result register and architectural flags.
    logic                   r_out_valid;
    logic [MAX_WIDTH-1:0]   r_out_result;
    logic                   r_out_wb;
    t_flags                 r_out_flags;
    t_flags                 r_flags;

    // Execute datapath.
    logic [MAX_WIDTH-1:0]   mask;
    logic [MAX_WIDTH-1:0]   top;
    logic [MAX_WIDTH-1:0]   opa;
    logic [MAX_WIDTH-1:0]   opb;
    logic [MAX_WIDTH-1:0]   opa_sx;
    logic [MAX_WIDTH-1:0]   opa_rep;
    logic [MAX_WIDTH:0]     cin_ext;
    logic [MAX_WIDTH:0]     sum;
    logic [MAX_WIDTH:0]     diff;
    logic                   add_carry;
    logic [4:0]             sh_cnt;
    logic [4:0]             rot_cnt;
    logic [2*MAX_WIDTH-1:0] rol_wide;
    logic [2*MAX_WIDTH-1:0] ror_wide;
    logic [MAX_WIDTH-1:0]   n_result;
    logic                   n_wb;
    t_flags                 n_flags;
    logic                   set_zsp;

    logic                   in_accept;
    logic                   advance;

    // The output register frees up when it is empty or being taken, so the
    // input register only holds off upstream when both stages are full and
    // the output is stalled.
    assign advance   = r_in_valid && !(r_out_valid && i_stall);
    assign o_stall   = r_in_valid && r_out_valid && i_stall;
    assign in_accept = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_op   <= i_operation;
            r_in_wsel <= i_operand_width;
            r_in_dest <= i_dest_value;
            r_in_src  <= i_src_value;
        end
    end

    // Width-dependent constants and operand views. Width code three acts as
    // thirty-two bits.
    always_comb begin
        case (r_in_wsel)
            WSEL_8: begin
                mask      = MAX_WIDTH'(32'h0000_00FF);
                top       = MAX_WIDTH'(32'h0000_0080);
                rot_cnt   = {2'b00, r_in_src[2:0]};
                opa_sx    = {{(MAX_WIDTH-8){r_in_dest[7]}}, r_in_dest[7:0]};
                opa_rep   = {(MAX_WIDTH/8){r_in_dest[7:0]}};
            end
            WSEL_16: begin
                mask      = MAX_WIDTH'(32'h0000_FFFF);
                top       = MAX_WIDTH'(32'h0000_8000);
                rot_cnt   = {1'b0, r_in_src[3:0]};
                opa_sx    = {{(MAX_WIDTH-16){r_in_dest[15]}}, r_in_dest[15:0]};
                opa_rep   = {(MAX_WIDTH/16){r_in_dest[15:0]}};
            end
            default: begin
                mask      = {MAX_WIDTH{1'b1}};
                top       = {1'b1, {(MAX_WIDTH-1){1'b0}}};
                rot_cnt   = r_in_src[4:0];
                opa_sx    = r_in_dest;
                opa_rep   = r_in_dest;
            end
        endcase
    end

    assign opa    = r_in_dest & mask;
    assign opb    = r_in_src & mask;
    assign sh_cnt = r_in_src[4:0];

    // Carry in is the stored CF only for ADC and SBB.
    assign cin_ext = {{MAX_WIDTH{1'b0}},
                      r_flags.cf && (r_in_op == OP_ADC || r_in_op == OP_SBB)};
    assign sum  = {1'b0, opa} + {1'b0, opb} + cin_ext;
    // Operands are zero-extended, so the top bit of the difference is the borrow.
    assign diff = {1'b0, opa} - {1'b0, opb} - cin_ext;

    // The carry out of an add sits just above the selected width.
    assign add_carry = (r_in_wsel == WSEL_8)  ? sum[8] :
                       (r_in_wsel == WSEL_16) ? sum[16] : sum[MAX_WIDTH];

    // Rotates work on the operand repeated across the word, which makes a
    // plain 32-bit rotate correct in the low bits of any width.
    assign rol_wide = {opa_rep, opa_rep} << rot_cnt;
    assign ror_wide = {opa_rep, opa_rep} >> rot_cnt;

    always_comb begin
        n_result = opa;
        n_wb     = 1'b1;
        n_flags  = r_flags;
        set_zsp  = 1'b1;
        case (r_in_op)
            OP_ADD, OP_ADC: begin
                n_result   = sum[MAX_WIDTH-1:0] & mask;
                n_flags.cf = add_carry;
                n_flags.of = |((opa ^ n_result) & (opb ^ n_result) & top);
            end
            OP_SUB, OP_SBB, OP_CMP: begin
                n_result   = diff[MAX_WIDTH-1:0] & mask;
                n_flags.cf = diff[MAX_WIDTH];
                n_flags.of = |((opa ^ opb) & (opa ^ n_result) & top);
                n_wb       = (r_in_op != OP_CMP);
            end
            OP_INC: begin
                n_result   = (opa + MAX_WIDTH'(1)) & mask;
                n_flags.of = (n_result == top);
            end
            OP_DEC: begin
                n_result   = (opa - MAX_WIDTH'(1)) & mask;
                n_flags.of = (opa == top);
            end
            OP_NEG: begin
                n_result   = (MAX_WIDTH'(0) - opa) & mask;
                n_flags.cf = (opa != '0);
                n_flags.of = (opa == top);
            end
            OP_AND, OP_TEST: begin
                n_result   = opa & opb;
                n_flags.cf = 1'b0;
                n_flags.of = 1'b0;
                n_wb       = (r_in_op != OP_TEST);
            end
            OP_OR: begin
                n_result   = opa | opb;
                n_flags.cf = 1'b0;
                n_flags.of = 1'b0;
            end
            OP_XOR: begin
                n_result   = opa ^ opb;
                n_flags.cf = 1'b0;
                n_flags.of = 1'b0;
            end
            OP_NOT: begin
                n_result = ~opa & mask;
                set_zsp  = 1'b0;
            end
            OP_SHL: begin
                n_result = (opa << sh_cnt) & mask;
            end
            OP_SHR: begin
                n_result = opa >> sh_cnt;
            end
            OP_SAR: begin
                // Shift the sign-extended operand; the fill lands in the
                // low bits of the width as the count grows.
                n_result = MAX_WIDTH'($signed(opa_sx) >>> sh_cnt) & mask;
            end
            OP_ROL: begin
                n_result = rol_wide[2*MAX_WIDTH-1:MAX_WIDTH] & mask;
            end
            OP_ROR: begin
                n_result = ror_wide[MAX_WIDTH-1:0] & mask;
            end
            default: begin
                // Unknown codes pass the destination through and write nothing.
                n_wb    = 1'b0;
                set_zsp = 1'b0;
            end
        endcase
        if (set_zsp) begin
            n_flags.zf = (n_result == '0);
            n_flags.sf = |(n_result & top);
            n_flags.pf = ~^n_result[7:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_flags     <= '0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
            r_flags     <= n_flags;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_result <= n_result;
            r_out_wb     <= n_wb;
            r_out_flags  <= n_flags;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_result_value = r_out_result;
    assign o_write_back   = r_out_wb;
    assign o_carry_out    = r_out_flags.cf;
    assign o_overflow_out = r_out_flags.of;
    assign o_zero_out     = r_out_flags.zf;
    assign o_sign_out     = r_out_flags.sf;
    assign o_parity_out   = r_out_flags.pf;

    // The flags may only move when a word executes.
    `X86_ALU_ASSERT_NEXT(a_flags_hold, i_clk, i_rst_n, !advance, $stable(r_flags), "flags changed with no word executing")
    // NOT leaves every flag alone.
    `X86_ALU_ASSERT_NEXT(a_not_keeps_flags, i_clk, i_rst_n, advance && r_in_op == OP_NOT, $stable(r_flags), "NOT altered the flags")
    // The logical group clears CF and OF.
    `X86_ALU_ASSERT_NEXT(a_logic_clears, i_clk, i_rst_n, advance && (r_in_op == OP_AND || r_in_op == OP_OR || r_in_op == OP_XOR || r_in_op == OP_TEST), !r_flags.cf && !r_flags.of, "logical op left CF or OF set")
    // The presented flags always match the flag register after execution.
    `X86_ALU_ASSERT_NEXT(a_out_flags_match, i_clk, i_rst_n, advance, r_out_flags == r_flags, "output flags differ from flag register")

endmodule

>>> tb/sv/alu_flag_checker.sv
// Checker for the x86 integer ALU: watches both channels, predicts every result word
// and compares it with what the block returns. Depends on x86alu_pkg only.
module alu_flag_checker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    input  logic                             i_in_stall,
    input  logic [x86alu_pkg::OP_W-1:0]      i_operation,
    input  logic [x86alu_pkg::WSEL_W-1:0]    i_operand_width,
    input  logic [x86alu_pkg::MAX_WIDTH-1:0] i_dest_value,
    input  logic [x86alu_pkg::MAX_WIDTH-1:0] i_src_value,
    input  logic                             i_out_valid,
    input  logic                             i_out_stall,
    input  logic [x86alu_pkg::MAX_WIDTH-1:0] i_result_value,
    input  logic                             i_write_back,
    input  logic                             i_carry_out,
    input  logic                             i_overflow_out,
    input  logic                             i_zero_out,
    input  logic                             i_sign_out,
    input  logic                             i_parity_out,
    output int                               o_fail_count,
    output int                               o_pending
);
    import x86alu_pkg::*;

    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic [MAX_WIDTH-1:0] result;
        logic                 write_back;
        t_flags               flags;
    } t_alu_word;

    t_flags    flag_state = '0;
    t_alu_word result_q[$];
    int        fails = 0;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    // The returned flags are also the new flag state, since every result echoes them.
    function automatic t_alu_word compute_alu(input logic [OP_W-1:0]      op,
                                              input logic [WSEL_W-1:0]    wsel,
                                              input logic [MAX_WIDTH-1:0] dest,
                                              input logic [MAX_WIDTH-1:0] src,
                                              input t_flags               fl);
        int unsigned w;
        int unsigned cnt;
        int unsigned keep;
        logic [63:0] mask;
        logic [63:0] topbit;
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] r;
        logic [63:0] cin;
        logic        upd_zsp;
        t_flags      f;
        t_alu_word   res;

        f = fl;
        res.write_back = 1'b1;
        upd_zsp = 1'b0;
        case (wsel)
            WSEL_8:  w = 8;
            WSEL_16: w = 16;
            default: w = 32;
        endcase
        if (w > MAX_WIDTH) w = MAX_WIDTH;
        mask   = (64'd1 << w) - 64'd1;
        topbit = 64'd1 << (w - 1);
        a   = {32'd0, dest} & mask;
        b   = {32'd0, src} & mask;
        cin = {63'd0, fl.cf};
        r   = a;

        case (op)
            OP_ADD, OP_ADC: begin
                if (op == OP_ADD) cin = 64'd0;
                r = a + b + cin;
                f.cf = ((r >> w) & 64'd1) != 64'd0;
                r = r & mask;
                f.of = ((a ^ r) & (b ^ r) & topbit) != 64'd0;
                upd_zsp = 1'b1;
            end
            OP_SUB, OP_SBB, OP_CMP: begin
                if (op != OP_SBB) cin = 64'd0;
                r = (a - b - cin) & mask;
                f.cf = a < (b + cin);
                f.of = ((a ^ b) & (a ^ r) & topbit) != 64'd0;
                upd_zsp = 1'b1;
                if (op == OP_CMP) res.write_back = 1'b0;
            end
            OP_INC: begin
                r = (a + 64'd1) & mask;
                f.of = (r == topbit);
                upd_zsp = 1'b1;
            end
            OP_DEC: begin
                r = (a - 64'd1) & mask;
                f.of = (a == topbit);
                upd_zsp = 1'b1;
            end
            OP_NEG: begin
                r = (64'd0 - a) & mask;
                f.cf = (a != 64'd0);
                f.of = (a == topbit);
                upd_zsp = 1'b1;
            end
            OP_AND, OP_OR, OP_TEST, OP_XOR: begin
                if (op == OP_OR) r = a | b;
                else if (op == OP_XOR) r = a ^ b;
                else r = a & b;
                f.cf = 1'b0;
                f.of = 1'b0;
                upd_zsp = 1'b1;
                if (op == OP_TEST) res.write_back = 1'b0;
            end
            OP_NOT: begin
                r = ~a & mask;
            end
            OP_SHL, OP_SHR, OP_SAR: begin
                cnt = b[4:0];
                if (op == OP_SHL) begin
                    r = (a << cnt) & mask;
                end else begin
                    r = a >> cnt;
                    if (op == OP_SAR && (a & topbit) != 64'd0) begin
                        keep = (cnt >= w) ? 0 : (w - cnt);
                        r = r | (mask & ~((64'd1 << keep) - 64'd1));
                    end
                end
                upd_zsp = 1'b1;
            end
            OP_ROL, OP_ROR: begin
                cnt = b % w;
                if (cnt != 0) begin
                    if (op == OP_ROL) r = ((a << cnt) | (a >> (w - cnt))) & mask;
                    else r = ((a >> cnt) | (a << (w - cnt))) & mask;
                end
                upd_zsp = 1'b1;
            end
            default: begin
                res.write_back = 1'b0;
            end
        endcase

        if (upd_zsp) begin
            f.zf = (r == 64'd0);
            f.sf = ((r >> (w - 1)) & 64'd1) != 64'd0;
            f.pf = ~(^r[7:0]);
        end
        res.result = r[MAX_WIDTH-1:0];
        res.flags  = f;
        return res;
    endfunction

    always @(posedge i_clk) begin : watch
        t_alu_word predicted;
        t_alu_word observed;
        t_alu_word oldest;

        if (!i_rst_n) begin
            flag_state = '0;
            result_q.delete();
        end else begin
            if (i_in_valid && !i_in_stall) begin
                predicted = compute_alu(i_operation, i_operand_width, i_dest_value,
                                        i_src_value, flag_state);
                flag_state = predicted.flags;
                result_q.push_back(predicted);
            end
            if (i_out_valid && !i_out_stall) begin
                observed.result     = i_result_value;
                observed.write_back = i_write_back;
                observed.flags      = '{cf: i_carry_out, of: i_overflow_out, zf: i_zero_out,
                                        sf: i_sign_out, pf: i_parity_out};
                if (result_q.size() == 0) begin
                    fails++;
                    if (fails <= REPORT_LIMIT)
                        $display("unexpected result word: result %h wb %b flags(c,o,z,s,p) %b",
                                 observed.result, observed.write_back, observed.flags);
                end else begin
                    oldest = result_q.pop_front();
                    if (observed.result !== oldest.result ||
                        observed.write_back !== oldest.write_back ||
                        observed.flags.cf !== oldest.flags.cf ||
                        observed.flags.of !== oldest.flags.of ||
                        observed.flags.zf !== oldest.flags.zf ||
                        observed.flags.sf !== oldest.flags.sf ||
                        observed.flags.pf !== oldest.flags.pf) begin
                        fails++;
                        if (fails <= REPORT_LIMIT)
                            $display("mismatch: expected result %h wb %b flags(c,o,z,s,p) %b, %s",
                                     oldest.result, oldest.write_back, oldest.flags,
                                     $sformatf("got result %h wb %b flags(c,o,z,s,p) %b",
                                               observed.result, observed.write_back,
                                               observed.flags));
                    end
                end
            end
        end
        o_fail_count <= fails;
        o_pending    <= result_q.size();
    end

endmodule

>>> tb/sv/tb_top.sv
// Top of the x86 integer ALU testbench: clock, reset, stimulus, receiver stalls and verdict.
// Depends on x86alu_pkg, the block x86_integer_alu_with_flags and alu_flag_checker.
module tb_top;
    import x86alu_pkg::*;

    // Width codes the package does not name. Code three behaves as thirty-two bits.
    localparam logic [WSEL_W-1:0] WSEL_32   = 2'd2;
    localparam logic [WSEL_W-1:0] WSEL_RSVD = 2'd3;

    // Operation codes above the last defined one are ignored by the block.
    localparam logic [OP_W-1:0] OP_FIRST_UNUSED = 5'd18;
    localparam logic [OP_W-1:0] OP_CODE_MAX     = 5'd31;

    localparam int ITEMS_PER_PHASE = 135;
    localparam int HOLD_OFF_CYCLES = 200;
    localparam int HOLD_OFF_AFTER  = 40;
    localparam int DRAIN_CYCLES    = 10;
    // Cycles without any accepted word before the run is declared hung. The longest
    // legitimate quiet stretch is the receiver hold-off, so this leaves a wide margin.
    localparam int WATCHDOG_LIMIT  = 2000;

    logic                 i_clk           = 1'b0;
    logic                 i_rst_n         = 1'b0;
    logic                 i_valid         = 1'b0;
    logic                 i_stall         = 1'b0;
    logic [OP_W-1:0]      i_operation     = '0;
    logic [WSEL_W-1:0]    i_operand_width = '0;
    logic [MAX_WIDTH-1:0] i_dest_value    = '0;
    logic [MAX_WIDTH-1:0] i_src_value     = '0;

    logic                 o_stall;
    logic                 o_valid;
    logic [MAX_WIDTH-1:0] o_result_value;
    logic                 o_write_back;
    logic                 o_carry_out;
    logic                 o_overflow_out;
    logic                 o_zero_out;
    logic                 o_sign_out;
    logic                 o_parity_out;

    int fail_count;
    int pending;

    // Idling rates in percent; the stimulus process changes them per phase.
    int sender_idle_pct = 0;
    int recv_stall_pct  = 0;

    // The stimulus process bumps this count to ask for one long receiver hold-off;
    // the receiver process notices the change and counts the hold-off itself.
    int hold_off_reqs = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    x86_integer_alu_with_flags u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_operation     (i_operation),
        .i_operand_width (i_operand_width),
        .i_dest_value    (i_dest_value),
        .i_src_value     (i_src_value),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_result_value  (o_result_value),
        .o_write_back    (o_write_back),
        .o_carry_out     (o_carry_out),
        .o_overflow_out  (o_overflow_out),
        .o_zero_out      (o_zero_out),
        .o_sign_out      (o_sign_out),
        .o_parity_out    (o_parity_out)
    );

    alu_flag_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_valid),
        .i_in_stall      (o_stall),
        .i_operation     (i_operation),
        .i_operand_width (i_operand_width),
        .i_dest_value    (i_dest_value),
        .i_src_value     (i_src_value),
        .i_out_valid     (o_valid),
        .i_out_stall     (i_stall),
        .i_result_value  (o_result_value),
        .i_write_back    (o_write_back),
        .i_carry_out     (o_carry_out),
        .i_overflow_out  (o_overflow_out),
        .i_zero_out      (o_zero_out),
        .i_sign_out      (o_sign_out),
        .i_parity_out    (o_parity_out),
        .o_fail_count    (fail_count),
        .o_pending       (pending)
    );

    // Receiver side. A requested hold-off keeps stall high until its hold-off count runs out,
    // so the block fills up and has to push back on the sender.
    int hold_seen = 0;
    int hold_left = 0;

    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            i_stall <= 1'b1;
            hold_left--;
        end else if (hold_seen != hold_off_reqs) begin
            hold_seen = hold_off_reqs;
            hold_left = HOLD_OFF_CYCLES - 1;
            i_stall <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // Offers one word and returns at the edge where it is accepted. Idle cycles come
    // before the word, so valid is only ever lowered or raised once per edge, and a
    // stalled word keeps its payload until it goes through.
    task automatic send_word(input logic [OP_W-1:0]      op,
                             input logic [WSEL_W-1:0]    wsel,
                             input logic [MAX_WIDTH-1:0] dest,
                             input logic [MAX_WIDTH-1:0] src);
        while ($urandom_range(99) < sender_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid         <= 1'b1;
        i_operation     <= op;
        i_operand_width <= wsel;
        i_dest_value    <= dest;
        i_src_value     <= src;
        do @(posedge i_clk); while (o_stall);
    endtask

    // Operands lean toward the values where flags change: zero, all ones, and the
    // sign boundary at each width. The rest are small values and full random words.
    function automatic logic [MAX_WIDTH-1:0] pick_operand();
        logic [MAX_WIDTH-1:0] sign_bit;

        sign_bit = 32'd1 << (8 * $urandom_range(1) + 16 * $urandom_range(1) + 7);
        if (sign_bit[23]) sign_bit = 32'h8000_0000;
        case ($urandom_range(7))
            0:       return '0;
            1:       return '1;
            2:       return sign_bit;
            3:       return sign_bit - 32'd1;
            4:       return MAX_WIDTH'($urandom_range(15));
            default: return $urandom();
        endcase
    endfunction

    task automatic send_random_word();
        logic [OP_W-1:0] op;

        // Mostly defined operations; now and then an unused code, which also drives
        // the upper operation bits.
        if ($urandom_range(9) == 0)
            op = OP_W'($urandom_range(OP_CODE_MAX, OP_FIRST_UNUSED));
        else
            op = OP_W'($urandom_range(OP_ROR));
        send_word(op, WSEL_W'($urandom_range(3)), pick_operand(), pick_operand());
    endtask

    // Directed words: carry and overflow edges at each width, chained carry into ADC
    // and borrow into SBB, flags kept by INC, NEG of zero and of the most negative
    // value, compare and test without write-back, NOT leaving the flags alone,
    // zero and oversized shift counts, sign fill, rotation by the full width,
    // the reserved width code and unused operation codes.
    task automatic run_directed();
        send_word(OP_ADD,  WSEL_8,    32'hFFFF_FFFF, 32'hFFFF_FF01);
        send_word(OP_ADC,  WSEL_8,    32'h0000_0010, 32'h0000_0020);
        send_word(OP_ADD,  WSEL_8,    32'h0000_007F, 32'h0000_0001);
        send_word(OP_SUB,  WSEL_16,   32'h0000_0000, 32'h0000_0001);
        send_word(OP_SBB,  WSEL_16,   32'h0000_1234, 32'h0000_0034);
        send_word(OP_CMP,  WSEL_32,   32'h8000_0000, 32'h0000_0001);
        send_word(OP_INC,  WSEL_16,   32'h0000_7FFF, 32'h0000_0000);
        send_word(OP_ADD,  WSEL_32,   32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_word(OP_INC,  WSEL_8,    32'h0000_00FF, 32'h0000_0000);
        send_word(OP_DEC,  WSEL_32,   32'h8000_0000, 32'h0000_0000);
        send_word(OP_NEG,  WSEL_8,    32'h0000_0000, 32'h0000_0000);
        send_word(OP_NEG,  WSEL_8,    32'h0000_0080, 32'h0000_0000);
        send_word(OP_AND,  WSEL_32,   32'hFFFF_FFFF, 32'hF0F0_F0F0);
        send_word(OP_OR,   WSEL_16,   32'hFFFF_0000, 32'h0000_0000);
        send_word(OP_TEST, WSEL_8,    32'h0000_00AA, 32'h0000_0055);
        send_word(OP_XOR,  WSEL_32,   32'hDEAD_BEEF, 32'hFFFF_FFFF);
        send_word(OP_NOT,  WSEL_16,   32'h0000_1234, 32'h0000_0000);
        send_word(OP_SHL,  WSEL_8,    32'h0000_0081, 32'hFFFF_FF00);
        send_word(OP_SHL,  WSEL_16,   32'h0000_FFFF, 32'h0000_0010);
        send_word(OP_SHR,  WSEL_32,   32'hFFFF_FFFF, 32'h0000_001F);
        send_word(OP_SAR,  WSEL_8,    32'h0000_0080, 32'h0000_0007);
        send_word(OP_SAR,  WSEL_16,   32'h0000_8000, 32'h0000_001F);
        send_word(OP_ROL,  WSEL_32,   32'h8000_0001, 32'h0000_0001);
        send_word(OP_ROR,  WSEL_8,    32'h0000_0001, 32'h0000_0008);
        send_word(OP_ROR,  WSEL_RSVD, 32'h1234_5678, 32'h0000_0004);
        send_word(OP_FIRST_UNUSED, WSEL_8,  32'h0000_00AB, 32'h0000_0000);
        send_word(OP_CODE_MAX,     WSEL_32, 32'hCAFE_F00D, 32'hFFFF_FFFF);
    endtask

    // Watchdog: any stretch of cycles with no word accepted on either channel that
    // reaches the limit means the block has hung, and the run ends as failed.
    initial begin : watchdog
        int quiet;

        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    initial begin : stimulus
        int n;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        run_directed();

        // Random phases: no idling, sender idle, receiver stalling, then both at once.
        // The long receiver hold-off falls inside the first phase, where the sender
        // offers a word every cycle and so keeps pressing on the full block.
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin
                    sender_idle_pct = 0;
                    recv_stall_pct  = 0;
                end
                1: begin
                    sender_idle_pct = 50;
                    recv_stall_pct  = 0;
                end
                2: begin
                    sender_idle_pct = 0;
                    recv_stall_pct  = 50;
                end
                default: begin
                    sender_idle_pct = 35;
                    recv_stall_pct  = 35;
                end
            endcase
            for (n = 0; n < ITEMS_PER_PHASE; n++) begin
                if (phase == 0 && n == HOLD_OFF_AFTER)
                    hold_off_reqs <= hold_off_reqs + 1;
                send_word_wrapper();
            end
        end
        i_valid <= 1'b0;

        // The pending count is registered, so it trails the last accepted word; let it catch
        // up before waiting on it. The watchdog bounds the wait if results stop coming.
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0 && pending == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    task automatic send_word_wrapper();
        send_random_word();
    endtask

endmodule
